// ===== rtl/pra_pkg.sv =====
// ----------------------------------------------------------------------------
// pra_pkg: shared types and constants of the page run allocator
// Field widths, command and status codes, register indexes and defaults.
// ----------------------------------------------------------------------------
package pra_pkg;

  localparam int MAP_PAGES_DEF     = 1024;
  localparam int PAGE_BYTES_DEF    = 4096;
  localparam int MAX_REQUEST_BYTES = 4194304;

  localparam int SIZE_W     = 23;
  localparam int PAGE_W     = 20;
  localparam int BRK_W      = 11;
  localparam int LIMIT_W    = 11;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [PAGE_W-1:0]  BASE_RESET  = 20'd0;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 11'd1024;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // register index, taken from paddr bit 2
  localparam logic REG_BASE  = 1'b0;
  localparam logic REG_LIMIT = 1'b1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_SPACE  = 2'd1,
    ST_ZERO_SIZE = 2'd2,
    ST_BAD_FREE  = 2'd3
  } status_t;

endpackage

// ===== rtl/pra_mem.sv =====
// ----------------------------------------------------------------------------
// pra_mem: page map memory
// One entry per page: used mark and page count of the allocation it belongs
// to. One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module pra_mem
  import pra_pkg::*;
#(
  parameter int MAP_PAGES = MAP_PAGES_DEF,
  parameter int CNT_W     = 11
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [$clog2(MAP_PAGES)-1:0] waddr,
  input  logic                         wused,
  input  logic [CNT_W-1:0]             wcnt,
  input  logic [$clog2(MAP_PAGES)-1:0] raddr,
  output logic                         rused,
  output logic [CNT_W-1:0]             rcnt
);

  logic [CNT_W:0] mem [MAP_PAGES];
  logic [CNT_W:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= {wused, wcnt};
    end
    rdata_r <= mem[raddr];
  end

  assign rused = rdata_r[CNT_W];
  assign rcnt  = rdata_r[CNT_W-1:0];

endmodule

// ===== rtl/pra_seq.sv =====
// ----------------------------------------------------------------------------
// pra_seq: allocator sequencer
// Rounds the request up to pages with a shift, scans the page map for an
// exact or largest run, extends the break, marks or clears pages and
// searches down for the new break after a free.
// ----------------------------------------------------------------------------
module pra_seq
  import pra_pkg::*;
#(
  parameter int MAP_PAGES  = MAP_PAGES_DEF,
  parameter int PAGE_BYTES = PAGE_BYTES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic                         in_command,
  input  logic [SIZE_W-1:0]            in_size_bytes,
  input  logic [PAGE_W-1:0]            in_page_number,
  input  logic [PAGE_W-1:0]            base_page,
  input  logic [LIMIT_W-1:0]           limit_pages,
  output logic                         out_valid,
  output logic [1:0]                   out_status,
  output logic [PAGE_W-1:0]            out_start_page,
  output logic [BRK_W-1:0]             out_break_pages,
  output logic                         mem_we,
  output logic [$clog2(MAP_PAGES)-1:0] mem_waddr,
  output logic                         mem_wused,
  output logic [$clog2((MAX_REQUEST_BYTES + PAGE_BYTES - 1) / PAGE_BYTES + 1)-1:0]
                                       mem_wcnt,
  output logic [$clog2(MAP_PAGES)-1:0] mem_raddr,
  input  logic                         mem_rused,
  input  logic [$clog2((MAX_REQUEST_BYTES + PAGE_BYTES - 1) / PAGE_BYTES + 1)-1:0]
                                       mem_rcnt
);

  localparam int IW    = $clog2(MAP_PAGES);
  localparam int CW    = $clog2(MAP_PAGES + 1);
  localparam int NMAX  = (MAX_REQUEST_BYTES + PAGE_BYTES - 1) / PAGE_BYTES;
  localparam int NW    = $clog2(NMAX + 1);
  localparam int W1    = (CW > NW) ? CW : NW;
  localparam int W2    = (W1 > PAGE_W) ? W1 : PAGE_W;
  localparam int LW    = W2 + 1;
  localparam int DW    = SIZE_W + 1;
  // page size is a power of two
  localparam int PB_SH = $clog2(PAGE_BYTES);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_PLACE, S_FILL, S_FRD, S_FCHK, S_DOWN
  } state_t;

  state_t             state_r, state_nxt;
  logic               cmd_r, cmd_nxt;
  logic [NW-1:0]      n_r, n_nxt;
  logic [IW-1:0]      off_r, off_nxt;
  logic [CW-1:0]      ridx_r, ridx_nxt;
  logic [IW-1:0]      pidx_r, pidx_nxt;
  logic               rvld_r, rvld_nxt;
  logic [IW-1:0]      run_at_r, run_at_nxt;
  logic [CW-1:0]      run_len_r, run_len_nxt;
  logic [IW-1:0]      best_at_r, best_at_nxt;
  logic [CW-1:0]      best_len_r, best_len_nxt;
  logic               have_r, have_nxt;
  logic [CW-1:0]      brk_r, brk_nxt;
  logic [CW-1:0]      wptr_r, wptr_nxt;
  logic [CW-1:0]      wend_r, wend_nxt;
  logic               endhit_r, endhit_nxt;
  logic               out_valid_r, out_valid_nxt;
  status_t            out_status_r, out_status_nxt;
  logic [PAGE_W-1:0]  out_start_r, out_start_nxt;
  logic [BRK_W-1:0]   out_break_r, out_break_nxt;

  logic [DW-1:0]      size_up;
  logic [LW-1:0]      n_w, len_w, brk_w, lim_w, end_w;
  logic               exact, better;
  logic [PAGE_W-1:0]  free_off;
  logic               free_bad;
  logic [CW-1:0]      ridx_dec, wptr_inc;

  // request rounded up to whole pages
  assign size_up = DW'(in_size_bytes) + DW'(PAGE_BYTES - 1);

  assign n_w    = LW'(n_r);
  assign len_w  = LW'(run_len_r);
  assign brk_w  = LW'(brk_r);
  assign lim_w  = (LW'(limit_pages) > LW'(MAP_PAGES)) ? LW'(MAP_PAGES) : LW'(limit_pages);
  assign exact  = (len_w == n_w);
  assign better = (len_w >= n_w) && (run_len_r > best_len_r);
  assign end_w  = LW'(off_r) + LW'(mem_rcnt);

  assign free_off = in_page_number - base_page;
  assign free_bad = (in_page_number < base_page) || (LW'(free_off) >= brk_w);

  assign ridx_dec = ridx_r - 1'b1;
  assign wptr_inc = wptr_r + 1'b1;

  assign mem_waddr = wptr_r[IW-1:0];
  assign mem_wused = (cmd_r == CMD_ALLOC);
  assign mem_wcnt  = (cmd_r == CMD_ALLOC) ? n_r : '0;

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    n_nxt          = n_r;
    off_nxt        = off_r;
    ridx_nxt       = ridx_r;
    pidx_nxt       = pidx_r;
    rvld_nxt       = rvld_r;
    run_at_nxt     = run_at_r;
    run_len_nxt    = run_len_r;
    best_at_nxt    = best_at_r;
    best_len_nxt   = best_len_r;
    have_nxt       = have_r;
    brk_nxt        = brk_r;
    wptr_nxt       = wptr_r;
    wend_nxt       = wend_r;
    endhit_nxt     = endhit_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_start_nxt  = out_start_r;
    out_break_nxt  = out_break_r;
    mem_we         = 1'b0;
    mem_raddr      = ridx_r[IW-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd_nxt = in_command;
          unique case (in_command)
            CMD_ALLOC: begin
              if (in_size_bytes == '0) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_ZERO_SIZE;
                out_start_nxt  = '0;
              end else if (in_size_bytes > SIZE_W'(MAX_REQUEST_BYTES)) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_NO_SPACE;
                out_start_nxt  = '0;
              end else begin
                n_nxt        = NW'(size_up >> PB_SH);
                ridx_nxt     = '0;
                rvld_nxt     = 1'b0;
                run_len_nxt  = '0;
                best_len_nxt = '0;
                have_nxt     = 1'b0;
                state_nxt    = S_SCAN;
              end
            end
            CMD_FREE: begin
              if (free_bad) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_BAD_FREE;
                out_start_nxt  = '0;
              end else begin
                off_nxt   = free_off[IW-1:0];
                state_nxt = S_FRD;
              end
            end
            default: ;
          endcase
        end
      end

      S_SCAN: begin
        // read of the next page overlaps the check of the previous one
        if (ridx_r != brk_r) begin
          ridx_nxt = ridx_r + 1'b1;
          pidx_nxt = ridx_r[IW-1:0];
          rvld_nxt = 1'b1;
        end else begin
          rvld_nxt = 1'b0;
        end
        if (rvld_r) begin
          if (mem_rused) begin
            if (exact) begin
              have_nxt    = 1'b1;
              best_at_nxt = run_at_r;
              state_nxt   = S_PLACE;
            end else if (better) begin
              have_nxt     = 1'b1;
              best_at_nxt  = run_at_r;
              best_len_nxt = run_len_r;
            end
            run_len_nxt = '0;
          end else begin
            if (run_len_r == '0) begin
              run_at_nxt = pidx_r;
            end
            run_len_nxt = run_len_r + 1'b1;
          end
        end else if (ridx_r == brk_r) begin
          // last run ends at the break
          if (exact || better) begin
            have_nxt    = 1'b1;
            best_at_nxt = run_at_r;
          end
          state_nxt = S_PLACE;
        end
      end

      S_PLACE: begin
        if (have_r) begin
          wptr_nxt      = CW'(best_at_r);
          wend_nxt      = CW'(LW'(best_at_r) + n_w);
          out_start_nxt = base_page + PAGE_W'(best_at_r);
          state_nxt     = S_FILL;
        end else if ((brk_w < lim_w) && (n_w <= lim_w - brk_w)) begin
          wptr_nxt      = brk_r;
          wend_nxt      = CW'(brk_w + n_w);
          brk_nxt       = CW'(brk_w + n_w);
          out_start_nxt = base_page + PAGE_W'(brk_r);
          state_nxt     = S_FILL;
        end else begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_NO_SPACE;
          out_start_nxt  = '0;
          state_nxt      = S_IDLE;
        end
      end

      S_FILL: begin
        mem_we   = 1'b1;
        wptr_nxt = wptr_inc;
        if (wptr_inc == wend_r) begin
          if (cmd_r == CMD_ALLOC) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_OK;
            state_nxt      = S_IDLE;
          end else if (endhit_r) begin
            // pages from off up to the break are now free
            ridx_nxt  = CW'(off_r);
            rvld_nxt  = 1'b0;
            state_nxt = S_DOWN;
          end else begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_OK;
            out_start_nxt  = '0;
            state_nxt      = S_IDLE;
          end
        end
      end

      S_FRD: begin
        mem_raddr = off_r;
        state_nxt = S_FCHK;
      end

      S_FCHK: begin
        if (!mem_rused) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_BAD_FREE;
          out_start_nxt  = '0;
          state_nxt      = S_IDLE;
        end else begin
          endhit_nxt = (end_w == brk_w);
          wend_nxt   = (end_w < brk_w) ? CW'(end_w) : brk_r;
          wptr_nxt   = CW'(off_r);
          state_nxt  = S_FILL;
        end
      end

      S_DOWN: begin
        mem_raddr = ridx_dec[IW-1:0];
        if (ridx_r != '0) begin
          ridx_nxt = ridx_dec;
          pidx_nxt = ridx_dec[IW-1:0];
          rvld_nxt = 1'b1;
        end else begin
          rvld_nxt = 1'b0;
        end
        if (rvld_r && mem_rused) begin
          brk_nxt        = CW'(pidx_r) + 1'b1;
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          out_start_nxt  = '0;
          state_nxt      = S_IDLE;
        end else if (!rvld_r && (ridx_r == '0)) begin
          brk_nxt        = '0;
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          out_start_nxt  = '0;
          state_nxt      = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    if (out_valid_nxt) begin
      out_break_nxt = BRK_W'(brk_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      brk_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      brk_r       <= brk_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r        <= cmd_nxt;
    n_r          <= n_nxt;
    off_r        <= off_nxt;
    ridx_r       <= ridx_nxt;
    pidx_r       <= pidx_nxt;
    rvld_r       <= rvld_nxt;
    run_at_r     <= run_at_nxt;
    run_len_r    <= run_len_nxt;
    best_at_r    <= best_at_nxt;
    best_len_r   <= best_len_nxt;
    have_r       <= have_nxt;
    wptr_r       <= wptr_nxt;
    wend_r       <= wend_nxt;
    endhit_r     <= endhit_nxt;
    out_status_r <= out_status_nxt;
    out_start_r  <= out_start_nxt;
    out_break_r  <= out_break_nxt;
  end

  assign busy            = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_start_page  = out_start_r;
  assign out_break_pages = out_break_r;

endmodule

// ===== rtl/page_run_allocator_top.sv =====
// ----------------------------------------------------------------------------
// page_run_allocator_top: page-granular heap allocator
// Command channel in, one result per item out, APB register port for the
// heap base page and the break limit.
// ----------------------------------------------------------------------------
// Usage: drive start with in_command (0 allocate, 1 free), in_size_bytes and
// in_page_number; the item is taken when start is high and busy is low.
// Every item gives exactly one result: out_valid is high for one cycle with
// out_status, out_start_page and out_break_pages. The receiver cannot stall.
// Flow: items that fail the first checks (zero size, oversize, free out of
// range) answer in the cycle after acceptance. An allocate scans the page
// map up to the break, places the run and marks its pages, paced by the page
// map, which is read or written one page a cycle; an exact fit ends the scan
// early. A free reads and checks the named page, clears its pages and, when
// the freed run ended at the break, searches down for the new break.
// Registers: 0 heap_base_page, 1 heap_limit_pages; write them only while the
// block is idle. Reset clears the break and base and presets the limit; the
// page map needs no clearing pass: only pages below the break are ever read.
// ----------------------------------------------------------------------------
module page_run_allocator_top
  import pra_pkg::*;
#(
  parameter int MAP_PAGES  = MAP_PAGES_DEF,
  parameter int PAGE_BYTES = PAGE_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic                  in_command,
  input  logic [SIZE_W-1:0]     in_size_bytes,
  input  logic [PAGE_W-1:0]     in_page_number,
  output logic                  out_valid,
  output logic [1:0]            out_status,
  output logic [PAGE_W-1:0]     out_start_page,
  output logic [BRK_W-1:0]      out_break_pages,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int IW = $clog2(MAP_PAGES);
  localparam int NW = $clog2((MAX_REQUEST_BYTES + PAGE_BYTES - 1) / PAGE_BYTES + 1);

  logic [PAGE_W-1:0]  base_r;
  logic [LIMIT_W-1:0] limit_r;
  logic               cfg_wr;

  logic               mem_we;
  logic [IW-1:0]      mem_waddr;
  logic               mem_wused;
  logic [NW-1:0]      mem_wcnt;
  logic [IW-1:0]      mem_raddr;
  logic               mem_rused;
  logic [NW-1:0]      mem_rcnt;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r  <= BASE_RESET;
      limit_r <= LIMIT_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_BASE:  base_r  <= pwdata[PAGE_W-1:0];
        REG_LIMIT: limit_r <= pwdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_BASE:  prdata = CFG_DATA_W'(base_r);
      REG_LIMIT: prdata = CFG_DATA_W'(limit_r);
      default:   prdata = '0;
    endcase
  end

  pra_seq #(
    .MAP_PAGES  (MAP_PAGES),
    .PAGE_BYTES (PAGE_BYTES)
  ) u_seq (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_command      (in_command),
    .in_size_bytes   (in_size_bytes),
    .in_page_number  (in_page_number),
    .base_page       (base_r),
    .limit_pages     (limit_r),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_start_page  (out_start_page),
    .out_break_pages (out_break_pages),
    .mem_we          (mem_we),
    .mem_waddr       (mem_waddr),
    .mem_wused       (mem_wused),
    .mem_wcnt        (mem_wcnt),
    .mem_raddr       (mem_raddr),
    .mem_rused       (mem_rused),
    .mem_rcnt        (mem_rcnt)
  );

  pra_mem #(
    .MAP_PAGES (MAP_PAGES),
    .CNT_W     (NW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wused (mem_wused),
    .wcnt  (mem_wcnt),
    .raddr (mem_raddr),
    .rused (mem_rused),
    .rcnt  (mem_rcnt)
  );

endmodule

// ===== rtl/pra_checker.sv =====
// ----------------------------------------------------------------------------
// pra_checker: port-level checks of the page run allocator
// Watches the command and result channels over time.
// ----------------------------------------------------------------------------
module pra_checker
  import pra_pkg::*;
#(
  parameter int MAP_PAGES = MAP_PAGES_DEF
) (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic              in_command,
  input logic [SIZE_W-1:0] in_size_bytes,
  input logic              out_valid,
  input logic [1:0]        out_status,
  input logic [PAGE_W-1:0] out_start_page,
  input logic [BRK_W-1:0]  out_break_pages
);

  // zero-size allocate answers at once
  a_zero_size: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_command == CMD_ALLOC) && (in_size_bytes == '0))
    |=> (out_valid && (out_status == ST_ZERO_SIZE)))
    else $error("zero-size allocate not answered next cycle");

  // oversize allocate fails at once
  a_oversize: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_command == CMD_ALLOC) && (in_size_bytes > MAX_REQUEST_BYTES))
    |=> (out_valid && (out_status == ST_NO_SPACE)))
    else $error("oversize allocate not rejected next cycle");

  a_fail_start: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != ST_OK)) |-> (out_start_page == '0))
    else $error("failed item reports a start page");

  a_break_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_break_pages <= MAP_PAGES))
    else $error("break beyond page map");

  // a result is only given once the item is finished
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result while still busy");

endmodule

bind page_run_allocator_top pra_checker #(
  .MAP_PAGES (MAP_PAGES)
) u_pra_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .in_command      (in_command),
  .in_size_bytes   (in_size_bytes),
  .out_valid       (out_valid),
  .out_status      (out_status),
  .out_start_page  (out_start_page),
  .out_break_pages (out_break_pages)
);

// ===== tb/sv/page_run_allocator_top_test.sv =====
// ----------------------------------------------------------------------------
// page_run_allocator_top_test: self-checking bench for the page run allocator
// Drives allocate and free items through the start/busy command port with
// random gaps, and reprograms base and limit over APB between phases. A
// scoreboard keeps its own page map, request sizes and break. It predicts
// every result and compares each strobed result field by field.
// ----------------------------------------------------------------------------
module page_run_allocator_top_test;
  import pra_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_CYCLES = 8 * (4 * MAP_PAGES_DEF + 256);
  localparam int DRAIN_CYCLES    = 64;
  localparam int RANDOM_PHASES   = 6;
  localparam int PHASE_ITEMS     = 45;

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  logic                  in_command;
  logic [SIZE_W-1:0]     in_size_bytes;
  logic [PAGE_W-1:0]     in_page_number;
  logic                  out_valid;
  logic [1:0]            out_status;
  logic [PAGE_W-1:0]     out_start_page;
  logic [BRK_W-1:0]      out_break_pages;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  page_run_allocator_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_command      (in_command),
    .in_size_bytes   (in_size_bytes),
    .in_page_number  (in_page_number),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_start_page  (out_start_page),
    .out_break_pages (out_break_pages),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  class page_heap_scoreboard;
    typedef struct {
      status_t           status;
      logic [PAGE_W-1:0] start_page;
      logic [BRK_W-1:0]  break_pages;
    } heap_result_t;

    heap_result_t      expected_q[$];
    bit                page_used[MAP_PAGES_DEF];
    int unsigned       page_bytes[MAP_PAGES_DEF];
    int unsigned       heap_break;
    logic [PAGE_W-1:0] base_page;
    int unsigned       limit_pages;
    int                failures;
    status_t           last_status;
    logic [PAGE_W-1:0] last_start;

    function new();
      foreach (page_used[p]) begin
        page_used[p] = 1'b0;
        page_bytes[p] = 0;
      end
      heap_break = 0;
      base_page = BASE_RESET;
      limit_pages = LIMIT_RESET;
      failures = 0;
    endfunction

    function void set_reg(logic idx, int unsigned value);
      if (idx == REG_BASE) begin
        base_page = value[PAGE_W-1:0];
      end else begin
        limit_pages = value & 32'h7FF;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // exact fit first, else the longest run that is long enough, lowest on ties
    function bit find_run(int unsigned n, output int unsigned at);
      int unsigned i, j, brk, best_len, best_at;
      bit have_best;
      i = 0;
      best_len = 0;
      best_at = 0;
      have_best = 1'b0;
      at = 0;
      brk = (heap_break > MAP_PAGES_DEF) ? MAP_PAGES_DEF : heap_break;
      while (i < brk) begin
        if (page_used[i]) begin
          i++;
        end else begin
          j = i;
          while (j < brk && !page_used[j]) j++;
          if (j - i == n) begin
            at = i;
            return 1'b1;
          end
          if (j - i >= n && j - i > best_len) begin
            best_len = j - i;
            best_at = i;
            have_best = 1'b1;
          end
          i = j;
        end
      end
      at = best_at;
      return have_best;
    endfunction

    function void note_item(logic cmd, logic [SIZE_W-1:0] size, logic [PAGE_W-1:0] page);
      heap_result_t      res;
      int unsigned       n, lim, at, ct, run_end, p, nb;
      logic [PAGE_W-1:0] off;
      res.status = ST_OK;
      res.start_page = '0;
      if (cmd == CMD_ALLOC) begin
        if (size == 0) begin
          res.status = ST_ZERO_SIZE;
        end else if (size > MAX_REQUEST_BYTES) begin
          res.status = ST_NO_SPACE;
        end else begin
          n = (size + PAGE_BYTES_DEF - 1) / PAGE_BYTES_DEF;
          lim = (limit_pages > MAP_PAGES_DEF) ? MAP_PAGES_DEF : limit_pages;
          if (!find_run(n, at)) begin
            if (heap_break < lim && n <= lim - heap_break) begin
              at = heap_break;
              heap_break += n;
            end else begin
              res.status = ST_NO_SPACE;
            end
          end
          if (res.status == ST_OK) begin
            for (p = at; p < at + n && p < MAP_PAGES_DEF; p++) begin
              page_used[p] = 1'b1;
              page_bytes[p] = size;
            end
            res.start_page = base_page + at[PAGE_W-1:0];
          end
        end
      end else begin
        off = page - base_page;
        if (page < base_page || off >= heap_break || off >= MAP_PAGES_DEF ||
            !page_used[off]) begin
          res.status = ST_BAD_FREE;
        end else begin
          // the size recorded at the named page sets the span, even mid-run
          ct = (page_bytes[off] + PAGE_BYTES_DEF - 1) / PAGE_BYTES_DEF;
          run_end = off + ct;
          for (p = off; p < run_end && p < heap_break && p < MAP_PAGES_DEF; p++) begin
            page_used[p] = 1'b0;
            page_bytes[p] = 0;
          end
          if (run_end == heap_break) begin
            nb = 0;
            for (p = heap_break; p > 0; p--) begin
              if (page_used[p-1]) begin
                nb = p;
                break;
              end
            end
            heap_break = nb;
          end
        end
      end
      res.break_pages = heap_break[BRK_W-1:0];
      last_status = res.status;
      last_start = res.start_page;
      expected_q.push_back(res);
    endfunction

    function void check_result(logic [1:0] st, logic [PAGE_W-1:0] sp, logic [BRK_W-1:0] bp);
      heap_result_t exp_res;
      if (expected_q.size() == 0) begin
        failures++;
        $display("%0t: result with no item pending: status %0d start_page %0h break %0d",
                 $time, st, sp, bp);
        return;
      end
      exp_res = expected_q.pop_front();
      if (st !== exp_res.status) begin
        failures++;
        $display("%0t: status expected %0d actual %0d", $time, exp_res.status, st);
      end
      if (sp !== exp_res.start_page) begin
        failures++;
        $display("%0t: start_page expected %0h actual %0h", $time, exp_res.start_page, sp);
      end
      if (bp !== exp_res.break_pages) begin
        failures++;
        $display("%0t: break_pages expected %0d actual %0d", $time, exp_res.break_pages, bp);
      end
    endfunction
  endclass

  typedef struct {
    int unsigned off;
    int unsigned pages;
  } live_run_t;

  page_heap_scoreboard sb;
  live_run_t           live_q[$];
  int                  stall_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) begin
        sb.check_result(out_status, out_start_page, out_break_pages);
      end
      if (start && !busy) begin
        sb.note_item(in_command, in_size_bytes, in_page_number);
      end
      if (out_valid || (start && !busy) || (psel && penable)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= WATCHDOG_CYCLES) begin
        $display("page_run_allocator_top: mismatch");
        $finish;
      end
    end
  end

  // leaves at the falling edge after the item is taken
  task automatic send_item(input logic cmd, input logic [SIZE_W-1:0] size,
                           input logic [PAGE_W-1:0] page);
    logic [PAGE_W-1:0] off;
    start <= 1'b1;
    in_command <= cmd;
    in_size_bytes <= size;
    in_page_number <= page;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    if (cmd == CMD_ALLOC && sb.last_status == ST_OK) begin
      off = sb.last_start - sb.base_page;
      live_q.push_back('{off: off, pages: (size + PAGE_BYTES_DEF - 1) / PAGE_BYTES_DEF});
    end
  endtask

  task automatic idle_gap(input bit quiet);
    int r, cycles;
    r = $urandom_range(0, 99);
    if (quiet || r < 50) cycles = 0;
    else if (r < 85) cycles = $urandom_range(1, 3);
    else if (r < 97) cycles = $urandom_range(4, 20);
    else cycles = $urandom_range(50, 200);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(negedge clk);
    end
  endtask

  // waits for the block to drain, writes the register and reads it back
  task automatic write_reg(input logic idx, input int unsigned value);
    logic [CFG_DATA_W-1:0] mask;
    mask = (idx == REG_BASE) ? 32'hFFFFF : 32'h7FF;
    start <= 1'b0;
    @(negedge clk);
    while (sb.pending() != 0 || busy) @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value & mask;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.set_reg(idx, value & mask);
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== (value & mask)) begin
      sb.failures++;
      $display("%0t: register %0d readback expected %0h actual %0h",
               $time, idx, value & mask, prdata);
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    int                phase, k, r, idx;
    bit                quiet;
    logic [SIZE_W-1:0] size;
    logic [PAGE_W-1:0] page;
    live_run_t         run;

    sb = new();
    stall_cycles = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_command = CMD_ALLOC;
    in_size_bytes = '0;
    in_page_number = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // zero size, oversize, whole map, full heap, free of the whole map and at the break
    send_item(CMD_ALLOC, 23'd0, 20'hFFFFF);
    send_item(CMD_ALLOC, 23'd4194305, 20'd0);
    send_item(CMD_ALLOC, 23'h7FFFFF, 20'd0);
    send_item(CMD_ALLOC, 23'd4194304, 20'd0);
    send_item(CMD_ALLOC, 23'd1, 20'd0);
    send_item(CMD_FREE, 23'h7FFFFF, 20'd0);
    send_item(CMD_FREE, 23'd0, 20'd0);
    // runs of 1, 2, 3 and 1 pages, then holes for exact and worst fit
    send_item(CMD_ALLOC, 23'd1, 20'd0);
    send_item(CMD_ALLOC, 23'd4097, 20'd0);
    send_item(CMD_ALLOC, 23'd12288, 20'd0);
    send_item(CMD_ALLOC, 23'd4096, 20'd0);
    send_item(CMD_FREE, 23'd0, 20'd3);
    send_item(CMD_FREE, 23'd0, 20'd0);
    send_item(CMD_ALLOC, 23'd8192, 20'd0);
    send_item(CMD_ALLOC, 23'd100, 20'd0);
    send_item(CMD_ALLOC, 23'd100, 20'd0);
    // free from inside a run, then the top run lowers the break
    send_item(CMD_FREE, 23'd0, 20'd2);
    send_item(CMD_FREE, 23'd0, 20'd6);
    send_item(CMD_FREE, 23'd0, 20'd1000);
    send_item(CMD_FREE, 23'd0, 20'd2);
    // limit below the break: only holes can be used
    write_reg(REG_BASE, 32'h100);
    write_reg(REG_LIMIT, 3);
    send_item(CMD_ALLOC, 23'd40000, 20'd0);
    send_item(CMD_ALLOC, 23'd4096, 20'd0);
    send_item(CMD_FREE, 23'd0, 20'h050);
    send_item(CMD_FREE, 23'd0, 20'h100);
    // start page wraps past the top of the page space
    write_reg(REG_BASE, 32'hFFFFF);
    write_reg(REG_LIMIT, 2047);
    send_item(CMD_ALLOC, 23'd12288, 20'd0);
    send_item(CMD_FREE, 23'd0, sb.last_start);

    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        1: write_reg(REG_BASE, 32'hFFFFF);
        2: write_reg(REG_BASE, 0);
        default: write_reg(REG_BASE, $urandom);
      endcase
      case (phase)
        0: write_reg(REG_LIMIT, 1024);
        1: write_reg(REG_LIMIT, 2047);
        2: write_reg(REG_LIMIT, $urandom_range(1, 1024));
        3: write_reg(REG_LIMIT, 0);
        4: write_reg(REG_LIMIT, 48);
        default: write_reg(REG_LIMIT, 1024);
      endcase
      quiet = (phase == 2);
      for (k = 0; k < PHASE_ITEMS; k++) begin
        r = $urandom_range(0, 99);
        if (live_q.size() != 0 && r < (sb.heap_break > 700 ? 70 : 40)) begin
          r = $urandom_range(0, 99);
          idx = $urandom_range(0, live_q.size() - 1);
          run = live_q[idx];
          if (r < 75) begin
            live_q.delete(idx);
            page = PAGE_W'(sb.base_page + run.off);
          end else if (r < 85 && run.pages > 1) begin
            page = PAGE_W'(sb.base_page + run.off + $urandom_range(1, run.pages - 1));
          end else if (r < 92) begin
            page = PAGE_W'(sb.base_page + $urandom_range(0, MAP_PAGES_DEF));
          end else begin
            page = PAGE_W'($urandom);
          end
          send_item(CMD_FREE, SIZE_W'($urandom), page);
        end else begin
          r = $urandom_range(0, 99);
          if (r < 45) size = SIZE_W'($urandom_range(1, 4 * PAGE_BYTES_DEF));
          else if (r < 70) size = SIZE_W'(PAGE_BYTES_DEF * $urandom_range(1, 16));
          else if (r < 85) size = SIZE_W'($urandom_range(1, 64 * PAGE_BYTES_DEF));
          else if (r < 90) size = SIZE_W'($urandom_range(1, MAX_REQUEST_BYTES));
          else if (r < 94) size = '0;
          else if (r < 97) size = SIZE_W'($urandom_range(MAX_REQUEST_BYTES + 1, 23'h7FFFFF));
          else size = SIZE_W'($urandom);
          send_item(CMD_ALLOC, size, PAGE_W'($urandom));
        end
        idle_gap(quiet);
      end
    end

    start <= 1'b0;
    @(negedge clk);
    while (sb.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (sb.failures == 0) begin
      $display("page_run_allocator_top: match");
    end else begin
      $display("page_run_allocator_top: mismatch");
    end
    $finish;
  end

endmodule
